>>> sv/gdd_pkg.sv
// ----------------------------------------------------------------------------
// gdd_pkg - shared types and constants for the date difference block
// Field widths, year bounds, calendar tables, status codes and lane results.
// ----------------------------------------------------------------------------
`default_nettype none

package gdd_pkg;

    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int YEAR_W   = 14;
    localparam int COUNT_W  = 22;
    localparam int STATUS_W = 2;
    // serial day number: 365 * 16383 plus corrections stays below 2^23
    localparam int SERIAL_W = 23;

    localparam int MIN_YEAR = 1000;
    localparam int MAX_YEAR = 9999;

    // x / 25 == (x * 1311) >> 15 for x < 4096
    localparam int RECIP25   = 1311;
    localparam int RECIP_SH  = 15;
    localparam int PROD_W    = 23;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FIRST_BAD  = 2'd1,
        ST_SECOND_BAD = 2'd2,
        ST_NOT_LATER  = 2'd3
    } t_status;

    typedef struct packed {
        logic                date_ok;
        logic [SERIAL_W-1:0] serial;
    } t_lane_res;

    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] v;
        case (m)
            4'd2:    v = 5'd28;
            4'd4:    v = 5'd30;
            4'd6:    v = 5'd30;
            4'd9:    v = 5'd30;
            4'd11:   v = 5'd30;
            default: v = 5'd31;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/gdd_in_if.sv
// ----------------------------------------------------------------------------
// gdd_in_if - request channel carrying a pair of dates
// Valid/ready handshake with the six date fields as payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdd_in_if;
    logic                         valid;
    logic                         ready;
    logic [gdd_pkg::MONTH_W-1:0]  first_month;
    logic [gdd_pkg::DAY_W-1:0]    first_day;
    logic [gdd_pkg::YEAR_W-1:0]   first_year;
    logic [gdd_pkg::MONTH_W-1:0]  second_month;
    logic [gdd_pkg::DAY_W-1:0]    second_day;
    logic [gdd_pkg::YEAR_W-1:0]   second_year;

    modport source (
        output valid, first_month, first_day, first_year,
               second_month, second_day, second_year,
        input  ready
    );
    modport sink (
        input  valid, first_month, first_day, first_year,
               second_month, second_day, second_year,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/gdd_out_if.sv
// ----------------------------------------------------------------------------
// gdd_out_if - result channel
// Valid/ready handshake with day count and status as payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdd_out_if;
    logic                          valid;
    logic                          ready;
    logic [gdd_pkg::COUNT_W-1:0]   day_count;
    logic [gdd_pkg::STATUS_W-1:0]  status;

    modport source (
        output valid, day_count, status,
        input  ready
    );
    modport sink (
        input  valid, day_count, status,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/gdd_lane.sv
// ----------------------------------------------------------------------------
// gdd_lane - per-date validity check and serial day number
// Two stages: constant products, then quotients, leap rule and the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_lane (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [gdd_pkg::MONTH_W-1:0]   i_month,
    input  wire logic [gdd_pkg::DAY_W-1:0]     i_day,
    input  wire logic [gdd_pkg::YEAR_W-1:0]    i_year,
    output gdd_pkg::t_lane_res                 o_res
);

    localparam int YW = gdd_pkg::YEAR_W;
    localparam int PW = gdd_pkg::PROD_W;
    localparam int SW = gdd_pkg::SERIAL_W;
    localparam int SH = gdd_pkg::RECIP_SH;

    // ---- stage 1 ----
    logic [YW-1:0]                 n_p;
    logic [SW-1:0]                 r_p365;
    logic [YW-3:0]                 r_p4;
    logic [PW-1:0]                 r_p100_prod;
    logic [PW-1:0]                 r_p400_prod;
    logic [YW-3:0]                 r_y4;
    logic [YW-5:0]                 r_y16;
    logic [PW-1:0]                 r_y100_prod;
    logic [PW-1:0]                 r_y400_prod;
    logic [3:0]                    r_ylo;
    logic                          r_year_ok;
    logic [gdd_pkg::MONTH_W-1:0]   r_month;
    logic [gdd_pkg::DAY_W-1:0]     r_day;

    assign n_p = i_year - YW'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p365      <= SW'(n_p) * SW'(365);
            r_p4        <= n_p[YW-1:2];
            r_p100_prod <= PW'(n_p[YW-1:2]) * PW'(gdd_pkg::RECIP25);
            r_p400_prod <= PW'(n_p[YW-1:4]) * PW'(gdd_pkg::RECIP25);
            r_y4        <= i_year[YW-1:2];
            r_y16       <= i_year[YW-1:4];
            r_y100_prod <= PW'(i_year[YW-1:2]) * PW'(gdd_pkg::RECIP25);
            r_y400_prod <= PW'(i_year[YW-1:4]) * PW'(gdd_pkg::RECIP25);
            r_ylo       <= i_year[3:0];
            r_year_ok   <= (i_year >= YW'(gdd_pkg::MIN_YEAR)) &&
                           (i_year <= YW'(gdd_pkg::MAX_YEAR));
            r_month     <= i_month;
            r_day       <= i_day;
        end
    end

    // ---- stage 2 ----
    logic [PW-SH-1:0]           c_p100, c_p400, c_y100, c_y400;
    logic                       c_leap;
    logic [gdd_pkg::DAY_W:0]    c_len;
    logic                       c_ok;
    logic [SW-1:0]              c_serial;

    always_comb begin
        c_p100 = r_p100_prod[PW-1:SH];
        c_p400 = r_p400_prod[PW-1:SH];
        c_y100 = r_y100_prod[PW-1:SH];
        c_y400 = r_y400_prod[PW-1:SH];
        // divisible by 4 but not 100, or divisible by 400
        c_leap = ((r_ylo[1:0] == 2'd0) &&
                  (r_y4 != (YW-2)'(c_y100) * (YW-2)'(25))) ||
                 ((r_ylo == 4'd0) &&
                  (r_y16 == (YW-4)'(c_y400) * (YW-4)'(25)));
        c_len  = {1'b0, gdd_pkg::month_len(r_month)} +
                 (gdd_pkg::DAY_W+1)'((r_month == 4'd2) && c_leap);
        c_ok   = r_year_ok && (r_month >= 4'd1) && (r_month <= 4'd12) &&
                 (r_day != '0) && ({1'b0, r_day} <= c_len);
        c_serial = r_p365 + SW'(r_p4) - SW'(c_p100) + SW'(c_p400) +
                   SW'(gdd_pkg::days_before_month(r_month)) + SW'(r_day) +
                   SW'((r_month > 4'd2) && c_leap);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.date_ok <= c_ok;
            o_res.serial  <= c_serial;
        end
    end

endmodule

`default_nettype wire

>>> sv/gdd_merge.sv
// ----------------------------------------------------------------------------
// gdd_merge - combines the two lane results
// Picks the status by priority, subtracts serials and saturates the count.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_merge (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire gdd_pkg::t_lane_res            i_first,
    input  wire gdd_pkg::t_lane_res            i_second,
    output logic [gdd_pkg::COUNT_W-1:0]        o_day_count,
    output logic [gdd_pkg::STATUS_W-1:0]       o_status
);

    localparam int SW = gdd_pkg::SERIAL_W;
    localparam int CW = gdd_pkg::COUNT_W;

    logic [SW-1:0]               c_diff;
    logic [CW-1:0]               n_count;
    gdd_pkg::t_status            n_status;

    always_comb begin
        c_diff   = i_second.serial - i_first.serial;
        n_count  = '0;
        n_status = gdd_pkg::ST_OK;
        if (!i_first.date_ok) begin
            n_status = gdd_pkg::ST_FIRST_BAD;
        end else if (!i_second.date_ok) begin
            n_status = gdd_pkg::ST_SECOND_BAD;
        end else if (i_second.serial <= i_first.serial) begin
            n_status = gdd_pkg::ST_NOT_LATER;
        end else if (c_diff > SW'({CW{1'b1}})) begin
            n_count = '1;
        end else begin
            n_count = c_diff[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_day_count <= n_count;
            o_status    <= n_status;
        end
    end

endmodule

`default_nettype wire

>>> sv/gregorian_date_difference_top.sv
// ----------------------------------------------------------------------------
// gregorian_date_difference_top - days between two Gregorian dates
//
//   channel   dir   modport   payload
//   i_req     in    sink      first/second month, day, year
//   o_rsp     out   source    day_count, status
//
// Two lane stages (products, then serial number) and the merge stage, which is
// also the output register. One request per cycle while the output is not stalled.
// The whole pipeline advances when the output register is empty or taken;
// a stalled output holds every stage. Reset clears only the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_difference_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gdd_in_if.sink     i_req,
    gdd_out_if.source  o_rsp
);

    logic                r_v1, r_v2, r_v3;
    logic                c_en;
    gdd_pkg::t_lane_res  c_first, c_second;

    assign c_en        = !r_v3 || o_rsp.ready;
    assign i_req.ready = c_en;
    assign o_rsp.valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (c_en) begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    gdd_lane u_lane_first (
        .i_clk   (i_clk),
        .i_en    (c_en),
        .i_month (i_req.first_month),
        .i_day   (i_req.first_day),
        .i_year  (i_req.first_year),
        .o_res   (c_first)
    );

    gdd_lane u_lane_second (
        .i_clk   (i_clk),
        .i_en    (c_en),
        .i_month (i_req.second_month),
        .i_day   (i_req.second_day),
        .i_year  (i_req.second_year),
        .o_res   (c_second)
    );

    gdd_merge u_merge (
        .i_clk       (i_clk),
        .i_en        (c_en),
        .i_first     (c_first),
        .i_second    (c_second),
        .o_day_count (o_rsp.day_count),
        .o_status    (o_rsp.status)
    );

endmodule

`default_nettype wire

>>> test/tb_gregorian_date_difference_top.sv
// ----------------------------------------------------------------------------
// tb_gregorian_date_difference_top - testbench for the date difference block
// Sends date pairs over the request channel and predicts the day count and
// status of each one. Responses are checked in order, with random idle
// bursts on both channels, one long output stall and repeated full drains.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gregorian_date_difference_top;

    localparam int MONTH_W          = gdd_pkg::MONTH_W;
    localparam int DAY_W            = gdd_pkg::DAY_W;
    localparam int YEAR_W           = gdd_pkg::YEAR_W;
    localparam int COUNT_W          = gdd_pkg::COUNT_W;
    localparam int STATUS_W         = gdd_pkg::STATUS_W;
    localparam int MIN_YEAR         = gdd_pkg::MIN_YEAR;
    localparam int MAX_YEAR         = gdd_pkg::MAX_YEAR;
    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 7;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int TIMEOUT_CYCLES   = 400000;
    localparam int unsigned COUNT_SAT = (1 << COUNT_W) - 1;

    typedef struct {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
    } t_cal_date;

    typedef struct {
        t_cal_date from_date;
        t_cal_date to_date;
    } t_date_pair;

    typedef struct {
        logic [COUNT_W-1:0] day_count;
        gdd_pkg::t_status   status;
    } t_date_diff;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gdd_in_if  req_if ();
    gdd_out_if rsp_if ();

    gregorian_date_difference_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---- calendar arithmetic ------------------------------------------------

    function automatic bit is_leap(int unsigned y);
        if (y % 400 == 0) return 1'b1;
        if (y % 100 == 0) return 1'b0;
        return (y % 4 == 0);
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        case (m)
            2:           return is_leap(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic bit date_valid(t_cal_date d);
        if (d.year < MIN_YEAR || d.year > MAX_YEAR || d.year == 0) return 1'b0;
        if (d.month < 1 || d.month > 12) return 1'b0;
        return d.day >= 1 && d.day <= days_in_month(d.month, d.year);
    endfunction

    // days since 0000-12-31 of the proleptic calendar; valid dates only
    function automatic int unsigned day_serial(t_cal_date d);
        int unsigned p;
        int unsigned n;
        p = d.year - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < d.month; k++) n += days_in_month(k, d.year);
        return n + d.day;
    endfunction

    // ---- scoreboard ---------------------------------------------------------

    class date_diff_scoreboard;
        t_date_diff  awaited_diffs[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        function t_date_diff predict_difference(t_date_pair p);
            t_date_diff  r;
            int unsigned s_from;
            int unsigned s_to;
            int unsigned span;
            r.day_count = '0;
            if (!date_valid(p.from_date)) begin
                r.status = gdd_pkg::ST_FIRST_BAD;
            end else if (!date_valid(p.to_date)) begin
                r.status = gdd_pkg::ST_SECOND_BAD;
            end else begin
                s_from = day_serial(p.from_date);
                s_to   = day_serial(p.to_date);
                if (s_to <= s_from) begin
                    r.status = gdd_pkg::ST_NOT_LATER;
                end else begin
                    r.status    = gdd_pkg::ST_OK;
                    span        = s_to - s_from;
                    r.day_count = (span > COUNT_SAT) ? COUNT_SAT[COUNT_W-1:0]
                                                     : span[COUNT_W-1:0];
                end
            end
            return r;
        endfunction

        function void note_request(t_date_pair p);
            awaited_diffs.push_back(predict_difference(p));
        endfunction

        function void check_result(logic [COUNT_W-1:0] day_count,
                                   logic [STATUS_W-1:0] status);
            t_date_diff exp_diff;
            if (awaited_diffs.size() == 0) begin
                $error("response with no request waiting: day_count %0d status %0d",
                       day_count, status);
                errors++;
                return;
            end
            exp_diff = awaited_diffs.pop_front();
            if (exp_diff.day_count !== day_count) begin
                $error("day_count: expected %0d, actual %0d", exp_diff.day_count, day_count);
                errors++;
            end
            if (exp_diff.status !== status) begin
                $error("status: expected %0d, actual %0d", exp_diff.status, status);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return awaited_diffs.size();
        endfunction
    endclass

    date_diff_scoreboard diff_board;

    int unsigned req_gap_pct   = 0;
    int unsigned rsp_stall_pct = 0;
    bit          long_hold_req = 1'b0;

    // ---- handshake monitor --------------------------------------------------

    always @(posedge i_clk) begin
        t_date_pair seen;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready)
                diff_board.check_result(rsp_if.day_count, rsp_if.status);
            if (req_if.valid && req_if.ready) begin
                seen.from_date.month = req_if.first_month;
                seen.from_date.day   = req_if.first_day;
                seen.from_date.year  = req_if.first_year;
                seen.to_date.month   = req_if.second_month;
                seen.to_date.day     = req_if.second_day;
                seen.to_date.year    = req_if.second_year;
                diff_board.note_request(seen);
            end
        end
    end

    // ---- response side ------------------------------------------------------

    initial begin : rsp_side
        rsp_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
                rsp_if.ready <= 1'b1;
            end else if (rsp_stall_pct != 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                rsp_if.ready <= 1'b1;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // ---- stimulus -----------------------------------------------------------

    function automatic t_date_pair make_pair(int unsigned m1, int unsigned d1,
                                             int unsigned y1, int unsigned m2,
                                             int unsigned d2, int unsigned y2);
        t_date_pair p;
        p.from_date.month = m1[MONTH_W-1:0];
        p.from_date.day   = d1[DAY_W-1:0];
        p.from_date.year  = y1[YEAR_W-1:0];
        p.to_date.month   = m2[MONTH_W-1:0];
        p.to_date.day     = d2[DAY_W-1:0];
        p.to_date.year    = y2[YEAR_W-1:0];
        return p;
    endfunction

    function automatic t_cal_date random_valid_date();
        t_cal_date   d;
        int unsigned y;
        int unsigned len;
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 9))
                0:       y = MIN_YEAR;
                1:       y = MAX_YEAR;
                2:       y = 1600;
                3:       y = 1700;
                4:       y = 1900;
                5:       y = 2000;
                6:       y = 2100;
                7:       y = 2400;
                8:       y = MIN_YEAR + 1;
                default: y = MAX_YEAR - 1;
            endcase
        end else begin
            y = $urandom_range(MIN_YEAR, MAX_YEAR);
        end
        d.year  = y[YEAR_W-1:0];
        d.month = MONTH_W'($urandom_range(1, 12));
        len     = days_in_month(d.month, y);
        d.day   = DAY_W'(($urandom_range(0, 9) < 3) ? len : $urandom_range(1, len));
        return d;
    endfunction

    function automatic t_cal_date random_raw_date();
        t_cal_date d;
        d.month = MONTH_W'($urandom_range(0, 15));
        d.day   = DAY_W'($urandom_range(0, 31));
        d.year  = YEAR_W'($urandom_range(0, 16383));
        return d;
    endfunction

    function automatic logic [22:0] date_key(t_cal_date d);
        return {d.year, d.month, d.day};
    endfunction

    function automatic t_date_pair random_pair();
        t_date_pair  p;
        t_cal_date   tmp;
        int unsigned sel;
        sel         = $urandom_range(0, 99);
        p.from_date = random_valid_date();
        p.to_date   = random_valid_date();
        if (sel < 65) begin
            // same-year pairs exercise month offsets and the leap day
            if (sel >= 50) begin
                p.to_date.year  = p.from_date.year;
                p.to_date.month = MONTH_W'($urandom_range(1, 12));
                p.to_date.day   = DAY_W'($urandom_range(1, days_in_month(p.to_date.month,
                                                                         p.to_date.year)));
            end
            if (date_key(p.from_date) > date_key(p.to_date)) begin
                tmp         = p.from_date;
                p.from_date = p.to_date;
                p.to_date   = tmp;
            end
        end else if (sel < 71) begin
            p.to_date = p.from_date;
        end else if (sel < 78) begin
            if (date_key(p.from_date) < date_key(p.to_date)) begin
                tmp         = p.from_date;
                p.from_date = p.to_date;
                p.to_date   = tmp;
            end
        end else if (sel < 88) begin
            // one past the end of the month, or a month out of range
            tmp = $urandom_range(0, 1) ? p.from_date : p.to_date;
            if ($urandom_range(0, 1))
                tmp.day = DAY_W'(days_in_month(tmp.month, tmp.year) + 1);
            else
                tmp.month = MONTH_W'($urandom_range(0, 1) ? 0 : $urandom_range(13, 15));
            if ($urandom_range(0, 1)) p.from_date = tmp;
            else                      p.to_date   = tmp;
        end else begin
            p.from_date = random_raw_date();
            p.to_date   = $urandom_range(0, 1) ? random_raw_date() : random_valid_date();
        end
        return p;
    endfunction

    task automatic send_pair(input t_date_pair p);
        if (req_gap_pct != 0 && $urandom_range(1, 100) <= req_gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.first_month  <= p.from_date.month;
        req_if.first_day    <= p.from_date.day;
        req_if.first_year   <= p.from_date.year;
        req_if.second_month <= p.to_date.month;
        req_if.second_day   <= p.to_date.day;
        req_if.second_year  <= p.to_date.year;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (diff_board.pending() != 0);
    endtask

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 8;
            2:       return 20;
            default: return 40;
        endcase
    endfunction

    task automatic run_random(input int unsigned n, input bit with_idle);
        for (int unsigned i = 0; i < n; i++) begin
            if (i % 50 == 0) begin
                req_gap_pct   = with_idle ? pick_idle_pct() : 0;
                rsp_stall_pct = with_idle ? pick_idle_pct() : 0;
            end
            send_pair(random_pair());
        end
    endtask

    initial begin : timeout
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : main
        int unsigned wait_cycles;
        diff_board          = new();
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.first_month  <= '0;
        req_if.first_day    <= '0;
        req_if.first_year   <= '0;
        req_if.second_month <= '0;
        req_if.second_day   <= '0;
        req_if.second_year  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        req_gap_pct   = 10;
        rsp_stall_pct = 10;
        // widest span, shortest span, equal and reversed order
        send_pair(make_pair(1, 1, MIN_YEAR, 12, 31, MAX_YEAR));
        send_pair(make_pair(1, 1, MIN_YEAR, 1, 2, MIN_YEAR));
        send_pair(make_pair(6, 15, 2020, 6, 15, 2020));
        send_pair(make_pair(6, 16, 2020, 6, 15, 2020));
        send_pair(make_pair(12, 31, MAX_YEAR, 1, 1, MIN_YEAR));
        // both invalid reports the first; second invalid ignores order
        send_pair(make_pair(0, 10, 2000, 13, 10, 2000));
        send_pair(make_pair(5, 5, 5000, 15, 5, 4000));
        send_pair(make_pair(5, 0, 5000, 5, 6, 5000));
        send_pair(make_pair(5, 5, 0, 5, 6, 5000));
        send_pair(make_pair(5, 5, MIN_YEAR - 1, 5, 6, 5000));
        send_pair(make_pair(5, 5, 5000, 5, 6, MAX_YEAR + 1));
        send_pair(make_pair(15, 31, 16383, 15, 31, 16383));
        send_pair(make_pair(14, 1, 2000, 3, 1, 2001));
        // leap rule: 400, 100, 4 and plain years
        send_pair(make_pair(2, 29, 2000, 3, 1, 2000));
        send_pair(make_pair(2, 29, 1900, 3, 1, 1900));
        send_pair(make_pair(2, 29, 2004, 3, 1, 2005));
        send_pair(make_pair(1, 1, 2001, 2, 29, 2001));
        send_pair(make_pair(2, 30, 2000, 3, 1, 2000));
        send_pair(make_pair(2, 28, 2400, 3, 1, 2400));
        send_pair(make_pair(2, 28, 2100, 3, 1, 2100));
        // month lengths and year rollover
        send_pair(make_pair(4, 31, 3000, 5, 1, 3000));
        send_pair(make_pair(4, 30, 3000, 5, 1, 3000));
        send_pair(make_pair(12, 31, 1999, 1, 1, 2000));
        send_pair(make_pair(1, 31, 7777, 12, 31, 9998));
        wait_for_results();

        run_random(600, 1'b1);

        // stall the output long enough for the pipeline to back up
        req_gap_pct   = 0;
        rsp_stall_pct = 0;
        long_hold_req = 1'b1;
        repeat (40) send_pair(random_pair());
        wait_for_results();

        run_random(550, 1'b1);
        run_random(150, 1'b0);

        req_if.valid <= 1'b0;
        wait_cycles = 0;
        do begin
            @(posedge i_clk);
            wait_cycles++;
        end while (diff_board.pending() != 0 && wait_cycles < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (diff_board.pending() != 0) begin
            $error("%0d expected responses never arrived", diff_board.pending());
            diff_board.errors++;
        end

        if (diff_board.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
sv/gdd_pkg.sv
sv/gdd_in_if.sv
sv/gdd_out_if.sv
sv/gdd_lane.sv
sv/gdd_merge.sv
sv/gregorian_date_difference_top.sv
test/tb_gregorian_date_difference_top.sv
